// ===== rtl/morse_character_keyer_assert.svh =====
// Assertion macros used by the keyer RTL
`ifndef MORSE_CHARACTER_KEYER_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define MCK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset
`define MCK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyer assertion failed");

`endif

// ===== rtl/mck_pkg.sv =====
// Shared constants, types and the character code table of the Morse keyer
`default_nettype none

package mck_pkg;

  localparam int CODE_W = 8;
  localparam int DIT_W  = 16;
  localparam int MUL_W  = 4;
  localparam int DUR_W  = DIT_W + MUL_W;
  localparam int PAT_W  = 6;
  localparam int LEN_W  = 3;
  localparam int ADDR_W = 3;

  localparam int MAX_ELEMENTS_DEF = 6;

  // register indexes on the configuration port
  localparam logic [ADDR_W-1:0] REG_DIT_TICKS     = 3'd0;
  localparam logic [ADDR_W-1:0] REG_DAH_MULTIPLE  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_CHAR_MULTIPLE = 3'd2;
  localparam logic [ADDR_W-1:0] REG_WORD_MULTIPLE = 3'd3;

  // register reset values
  localparam logic [DIT_W-1:0] DIT_TICKS_RST     = 16'd180;
  localparam logic [MUL_W-1:0] DAH_MULTIPLE_RST  = 4'd4;
  localparam logic [MUL_W-1:0] CHAR_MULTIPLE_RST = 4'd4;
  localparam logic [MUL_W-1:0] WORD_MULTIPLE_RST = 4'd6;

  // character codes with special handling
  localparam logic [CODE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CODE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CODE_W-1:0] CASE_DIFF  = 8'h20;

  // one table entry: element count (zero for unknown) and dah bits, right aligned
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] bits;
  } sym_entry_t;

  // fold lowercase letters to uppercase
  function automatic logic [CODE_W-1:0] fold_upper(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] r;
    r = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) r = c - CASE_DIFF;
    return r;
  endfunction

  // look up an uppercase code; unknown codes, NUL and the upper half give len zero
  function automatic sym_entry_t sym_lookup(input logic [CODE_W-1:0] c);
    sym_entry_t e;
    unique case (c)
      8'h41: e = '{3'd2, 6'h01}; // A
      8'h42: e = '{3'd4, 6'h08};
      8'h43: e = '{3'd4, 6'h0A};
      8'h44: e = '{3'd3, 6'h04};
      8'h45: e = '{3'd1, 6'h00};
      8'h46: e = '{3'd4, 6'h02};
      8'h47: e = '{3'd3, 6'h06};
      8'h48: e = '{3'd4, 6'h00};
      8'h49: e = '{3'd2, 6'h00};
      8'h4A: e = '{3'd4, 6'h07};
      8'h4B: e = '{3'd3, 6'h05};
      8'h4C: e = '{3'd4, 6'h04};
      8'h4D: e = '{3'd2, 6'h03};
      8'h4E: e = '{3'd2, 6'h02};
      8'h4F: e = '{3'd3, 6'h07};
      8'h50: e = '{3'd4, 6'h06};
      8'h51: e = '{3'd4, 6'h0D};
      8'h52: e = '{3'd3, 6'h02};
      8'h53: e = '{3'd3, 6'h00};
      8'h54: e = '{3'd1, 6'h01};
      8'h55: e = '{3'd3, 6'h01};
      8'h56: e = '{3'd4, 6'h01};
      8'h57: e = '{3'd3, 6'h03};
      8'h58: e = '{3'd4, 6'h09};
      8'h59: e = '{3'd4, 6'h0B};
      8'h5A: e = '{3'd4, 6'h0C}; // Z
      8'h30: e = '{3'd5, 6'h1F}; // digits
      8'h31: e = '{3'd5, 6'h0F};
      8'h32: e = '{3'd5, 6'h07};
      8'h33: e = '{3'd5, 6'h03};
      8'h34: e = '{3'd5, 6'h01};
      8'h35: e = '{3'd5, 6'h00};
      8'h36: e = '{3'd5, 6'h10};
      8'h37: e = '{3'd5, 6'h18};
      8'h38: e = '{3'd5, 6'h1C};
      8'h39: e = '{3'd5, 6'h1E};
      8'h2E: e = '{3'd6, 6'h15}; // full stop
      8'h2C: e = '{3'd6, 6'h33}; // comma
      8'h3A: e = '{3'd6, 6'h38}; // colon
      8'h3F: e = '{3'd6, 6'h0C}; // question mark
      8'h27: e = '{3'd6, 6'h1E}; // apostrophe
      8'h2D: e = '{3'd6, 6'h21}; // hyphen
      8'h2F: e = '{3'd5, 6'h12}; // slash
      8'h22: e = '{3'd6, 6'h12}; // double quote
      8'h40: e = '{3'd6, 6'h1A}; // at sign
      8'h3D: e = '{3'd5, 6'h11}; // equals
      default: e = '{3'd0, 6'h00};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/morse_character_keyer.sv =====
// Morse keyer: one character word in, a run of timed key on / key off words out
// Accepted characters pass S_DECODE, S_MUL and S_PUT to their first interval word.
// Each interval is a bit-serial dit multiply (S_MUL) and a load (S_PUT), which
//   waits on out_stall; the next character is taken only back in S_IDLE.
// Unknown codes give no words.
// Reset (rst, synchronous) empties the output stage, idles the sequencer and
//   restores dit 180 ticks, dah 4, character gap 4 and word gap 6 dits.
`default_nettype none

module morse_character_keyer
  import mck_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration writes
  input  wire logic               cfg_wen,
  input  wire logic [ADDR_W-1:0]  cfg_addr,
  input  wire logic [DIT_W-1:0]   cfg_wdata,
  // character input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CODE_W-1:0]  char_code,
  // interval output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    key_on,
  output logic [DUR_W-1:0]        duration,
  output logic                    last
);

  localparam int EW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_DECODE, S_MUL, S_PUT} state_t;
  typedef enum logic [1:0] {P_ON, P_OFF, P_TAIL} phase_t;

  state_t             state;
  phase_t             phase;
  logic [CODE_W-1:0]  char_reg;
  logic [PAT_W-1:0]   pat;
  logic [EW-1:0]      elem_left;
  logic [DUR_W-1:0]   mul_acc;
  logic [MUL_W-1:0]   mul_digits;
  logic [1:0]         mul_cnt;

  logic [DIT_W-1:0]   dit_ticks;
  logic [MUL_W-1:0]   dah_multiple;
  logic [MUL_W-1:0]   char_multiple;
  logic [MUL_W-1:0]   word_multiple;

  logic [CODE_W-1:0]  up_code;
  sym_entry_t         entry;
  logic [PAT_W-1:0]   pat_al;
  logic [EW-1:0]      n_elem;
  logic [MUL_W-1:0]   first_mult;
  logic [MUL_W-1:0]   next_mult;
  logic               out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dit_ticks     <= DIT_TICKS_RST;
      dah_multiple  <= DAH_MULTIPLE_RST;
      char_multiple <= CHAR_MULTIPLE_RST;
      word_multiple <= WORD_MULTIPLE_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_DIT_TICKS:     dit_ticks     <= cfg_wdata;
        REG_DAH_MULTIPLE:  dah_multiple  <= cfg_wdata[MUL_W-1:0];
        REG_CHAR_MULTIPLE: char_multiple <= cfg_wdata[MUL_W-1:0];
        REG_WORD_MULTIPLE: word_multiple <= cfg_wdata[MUL_W-1:0];
        default: ;
      endcase
    end
  end

  // decode the held character: fold case, look up, left-align the dah bits
  always_comb begin
    up_code    = fold_upper(char_reg);
    entry      = sym_lookup(up_code);
    pat_al     = entry.bits << (LEN_W'(PAT_W) - entry.len);
    n_elem     = (int'(entry.len) > MAX_ELEMENTS) ? EW'(MAX_ELEMENTS) : EW'(entry.len);
    first_mult = pat_al[PAT_W-1] ? dah_multiple : MUL_W'(1);
    next_mult  = pat[PAT_W-1] ? dah_multiple : MUL_W'(1);
    out_free   = !out_valid || !out_stall;
  end

  assign in_stall = (state != S_IDLE);

  // sequencer, bit-serial multiplier and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the output word once taken, unless a new one loads in its place
      if (out_valid && !out_stall && state != S_PUT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            char_reg <= char_code;
            state    <= S_DECODE;
          end
        end

        S_DECODE: begin
          mul_acc <= '0;
          mul_cnt <= '0;
          if (char_reg == CH_SPACE) begin
            phase      <= P_TAIL;
            mul_digits <= word_multiple;
            state      <= S_MUL;
          end else if (entry.len == '0) begin
            state <= S_IDLE;
          end else begin
            phase      <= P_ON;
            pat        <= pat_al;
            elem_left  <= n_elem;
            mul_digits <= first_mult;
            state      <= S_MUL;
          end
        end

        // one multiplier digit a cycle, most significant first
        S_MUL: begin
          mul_acc    <= {mul_acc[DUR_W-2:0], 1'b0} +
                        (mul_digits[MUL_W-1] ? {{MUL_W{1'b0}}, dit_ticks} : '0);
          mul_digits <= {mul_digits[MUL_W-2:0], 1'b0};
          mul_cnt    <= mul_cnt + 2'd1;
          if (mul_cnt == 2'(MUL_W - 1)) state <= S_PUT;
        end

        S_PUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            key_on    <= (phase == P_ON);
            last      <= (phase == P_TAIL);
            duration  <= mul_acc;
            mul_acc   <= '0;
            mul_cnt   <= '0;
            unique case (phase)
              P_ON: begin
                phase      <= P_OFF;
                pat        <= {pat[PAT_W-2:0], 1'b0};
                mul_digits <= MUL_W'(1);
                state      <= S_MUL;
              end
              P_OFF: begin
                elem_left <= elem_left - EW'(1);
                if (elem_left == EW'(1)) begin
                  phase      <= P_TAIL;
                  mul_digits <= char_multiple;
                end else begin
                  phase      <= P_ON;
                  mul_digits <= next_mult;
                end
                state <= S_MUL;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `include "morse_character_keyer_assert.svh"

  `MCK_ASSERT_NOW(a_tone_not_last, out_valid && key_on, !last)
  `MCK_ASSERT_NOW(a_elem_left_live,
      (state == S_MUL || state == S_PUT) && (phase == P_ON || phase == P_OFF),
      elem_left != '0)
  `MCK_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state == S_DECODE)

endmodule

`default_nettype wire
